@@ sv/tras_pkg.sv @@
// ----------------------------------------------------------------------------
// tras_pkg
// Shared types and constants for the threshold run alarm statistics unit.
// ----------------------------------------------------------------------------
package tras_pkg;

    localparam int COUNT_BITS = 16;
    localparam int TEMP_W     = 12;
    localparam int RUN_W      = 8;
    localparam int SUM_W      = COUNT_BITS + 12;
    localparam int PCT_W      = 14;
    localparam int DIV_W      = COUNT_BITS + PCT_W;
    localparam int QUO_W      = 14;
    localparam int STEP_W     = $clog2(QUO_W);
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 12;

    localparam logic signed [TEMP_W-1:0] TEMP_LOW  = -12'sd800;
    localparam logic signed [TEMP_W-1:0] TEMP_HIGH = 12'sd1600;
    localparam logic [RUN_W-1:0]         RUN_MAX   = '1;
    localparam logic [PCT_W-1:0]         PCT_SCALE = 14'd10000;

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_RUN_LEN   = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_MEAN_LOAD,
        ST_MEAN_DIV,
        ST_PCT_LOAD,
        ST_PCT_DIV,
        ST_FINISH
    } tras_state_t;

    typedef struct packed {
        logic update;
        logic div_load;
        logic div_sel_pct;
        logic div_step;
        logic mean_save;
        logic out_load;
    } tras_ctrl_t;

    typedef struct packed {
        logic                           sample_ok;
        logic                           above;
        logic [RUN_W-1:0]               run;
        logic                           alarm;
        logic [COUNT_BITS-1:0]          count;
        logic signed [SUM_W-1:0]        sum;
        logic signed [TEMP_W-1:0]       max_val;
        logic signed [TEMP_W-1:0]       min_val;
        logic [COUNT_BITS-1:0]          above_cnt;
    } tras_stats_t;

endpackage

@@ sv/tras_div.sv @@
// ----------------------------------------------------------------------------
// tras_div
// Shared restoring divider, one quotient bit per step, QUO_W steps per divide.
// ----------------------------------------------------------------------------
module tras_div
    import tras_pkg::*;
(
    input  logic                  clk,
    input  logic                  load,
    input  logic                  step,
    input  logic [DIV_W-1:0]      dividend,
    input  logic [COUNT_BITS-1:0] divisor,
    output logic [QUO_W-1:0]      quotient
);

    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] dsr_reg, dsr_next;
    logic [QUO_W-1:0] quo_reg, quo_next;
    logic [DIV_W:0]   diff;

    assign diff = {1'b0, rem_reg} - {1'b0, dsr_reg};

    always_comb
    begin
        rem_next = rem_reg;
        dsr_next = dsr_reg;
        quo_next = quo_reg;
        if (load)
        begin
            rem_next = dividend;
            dsr_next = DIV_W'(divisor) << (QUO_W - 1);
            quo_next = '0;
        end
        else if (step)
        begin
            if (!diff[DIV_W])
            begin
                rem_next = diff[DIV_W-1:0];
            end
            quo_next = {quo_reg[QUO_W-2:0], ~diff[DIV_W]};
            dsr_next = dsr_reg >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        quo_reg <= quo_next;
    end

    assign quotient = quo_reg;

endmodule

@@ sv/tras_stats.sv @@
// ----------------------------------------------------------------------------
// tras_stats
// Configuration registers, sample capture and running statistics update.
// ----------------------------------------------------------------------------
module tras_stats
    import tras_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         sample_load,
    input  logic signed [TEMP_W-1:0]     temperature,
    input  logic                         update,
    input  logic                         cfg_we,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data,
    output tras_stats_t                  stats
);

    logic signed [TEMP_W-1:0] threshold_reg;
    logic [RUN_W-1:0]         run_len_reg;
    logic signed [TEMP_W-1:0] sample_reg;

    logic                     ok_reg, ok_next;
    logic                     above_reg, above_next;
    logic [RUN_W-1:0]         run_reg, run_next;
    logic                     alarm_reg, alarm_next;
    logic [COUNT_BITS-1:0]    count_reg, count_next;
    logic signed [SUM_W-1:0]  sum_reg, sum_next;
    logic signed [TEMP_W-1:0] max_reg, max_next;
    logic signed [TEMP_W-1:0] min_reg, min_next;
    logic [COUNT_BITS-1:0]    acnt_reg, acnt_next;

    logic ok, above, empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= '0;
            run_len_reg   <= RUN_W'(3);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_THRESHOLD: threshold_reg <= cfg_data;
                REG_RUN_LEN:   run_len_reg   <= cfg_data[RUN_W-1:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_load)
        begin
            sample_reg <= temperature;
        end
    end

    assign ok    = !alarm_reg && (sample_reg >= TEMP_LOW) && (sample_reg <= TEMP_HIGH);
    assign above = ok && (sample_reg > threshold_reg);
    assign empty = (count_reg == '0);

    always_comb
    begin
        ok_next    = ok_reg;
        above_next = above_reg;
        run_next   = run_reg;
        alarm_next = alarm_reg;
        count_next = count_reg;
        sum_next   = sum_reg;
        max_next   = max_reg;
        min_next   = min_reg;
        acnt_next  = acnt_reg;
        if (update)
        begin
            ok_next    = ok;
            above_next = above;
            if (ok)
            begin
                if (empty || sample_reg > max_reg)
                begin
                    max_next = sample_reg;
                end
                if (empty || sample_reg < min_reg)
                begin
                    min_next = sample_reg;
                end
                if (count_reg != '1)
                begin
                    count_next = count_reg + 1'b1;
                    sum_next   = sum_reg + SUM_W'(sample_reg);
                    if (above)
                    begin
                        acnt_next = acnt_reg + 1'b1;
                    end
                end
                if (above)
                begin
                    run_next = (run_reg == RUN_MAX) ? run_reg : run_reg + 1'b1;
                end
                else
                begin
                    run_next = '0;
                end
                if (run_next >= run_len_reg)
                begin
                    alarm_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ok_reg    <= 1'b0;
            above_reg <= 1'b0;
            run_reg   <= '0;
            alarm_reg <= 1'b0;
            count_reg <= '0;
            sum_reg   <= '0;
            max_reg   <= '0;
            min_reg   <= '0;
            acnt_reg  <= '0;
        end
        else
        begin
            ok_reg    <= ok_next;
            above_reg <= above_next;
            run_reg   <= run_next;
            alarm_reg <= alarm_next;
            count_reg <= count_next;
            sum_reg   <= sum_next;
            max_reg   <= max_next;
            min_reg   <= min_next;
            acnt_reg  <= acnt_next;
        end
    end

    assign stats.sample_ok = ok_reg;
    assign stats.above     = above_reg;
    assign stats.run       = run_reg;
    assign stats.alarm     = alarm_reg;
    assign stats.count     = count_reg;
    assign stats.sum       = sum_reg;
    assign stats.max_val   = max_reg;
    assign stats.min_val   = min_reg;
    assign stats.above_cnt = acnt_reg;

endmodule

@@ sv/tras_ctrl.sv @@
// ----------------------------------------------------------------------------
// tras_ctrl
// Sequencer: statistics update, mean divide, percent divide, result load.
// ----------------------------------------------------------------------------
module tras_ctrl
    import tras_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       out_busy,
    output logic       in_stall,
    output tras_ctrl_t ctrl
);

    tras_state_t      state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              last_step;

    assign last_step = (step_reg == '0);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:      state_next = in_valid ? ST_UPDATE : ST_IDLE;
            ST_UPDATE:    state_next = ST_MEAN_LOAD;
            ST_MEAN_LOAD: state_next = ST_MEAN_DIV;
            ST_MEAN_DIV:  state_next = last_step ? ST_PCT_LOAD : ST_MEAN_DIV;
            ST_PCT_LOAD:  state_next = ST_PCT_DIV;
            ST_PCT_DIV:   state_next = last_step ? ST_FINISH : ST_PCT_DIV;
            ST_FINISH:    state_next = out_busy ? ST_FINISH : ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctrl      = '0;
        in_stall  = 1'b1;
        step_next = step_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
            end
            ST_UPDATE:
            begin
                ctrl.update = 1'b1;
            end
            ST_MEAN_LOAD:
            begin
                ctrl.div_load = 1'b1;
                step_next     = STEP_W'(QUO_W - 1);
            end
            ST_MEAN_DIV, ST_PCT_DIV:
            begin
                ctrl.div_step = 1'b1;
                step_next     = step_reg - 1'b1;
            end
            ST_PCT_LOAD:
            begin
                ctrl.div_load    = 1'b1;
                ctrl.div_sel_pct = 1'b1;
                ctrl.mean_save   = 1'b1;
                step_next        = STEP_W'(QUO_W - 1);
            end
            ST_FINISH:
            begin
                ctrl.out_load = !out_busy;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

@@ sv/threshold_run_alarm_stats_unit.sv @@
// ----------------------------------------------------------------------------
// threshold_run_alarm_stats_unit
// Temperature sample statistics with a consecutive over-threshold alarm.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall) carries one signed 1/16 C sample per
// transfer. Each transfer yields exactly one result transfer on the output
// channel (out_valid / out_stall) with the running statistics, the mean and
// the percent above threshold.
// From its transfer until its result is valid, one sample passes through an
// update state, then two 14-step passes through the shared restoring divider
// (mean, then percent), each with a load state, and a finish state that loads the result.
// The next sample is taken only after the result is loaded, so a new sample
// is not accepted while the last one is in progress; a result waiting in the
// output register does not block the next sample until that sample's result is ready.
// Configuration (threshold, alarm_run_length) is written through cfg_valid /
// cfg_ready, always ready, by the user only while the block is idle (unenforced).
// Reset clears all statistics and the alarm, sets threshold to 0 and the run
// length to 3. A stalled result holds its payload until taken.
// ----------------------------------------------------------------------------
module threshold_run_alarm_stats_unit
    import tras_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [TEMP_W-1:0]     temperature,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         sample_valid,
    output logic                         above_limit,
    output logic [RUN_W-1:0]             run_length,
    output logic                         alarm,
    output logic [COUNT_BITS-1:0]        reading_count,
    output logic signed [TEMP_W-1:0]     highest,
    output logic signed [TEMP_W-1:0]     lowest,
    output logic [COUNT_BITS-1:0]        above_count,
    output logic signed [TEMP_W-1:0]     mean_temp,
    output logic [PCT_W-1:0]             percent_above
);

    tras_ctrl_t  ctrl;
    tras_stats_t stats;
    logic        out_valid_reg;
    logic        out_busy;
    logic        sum_neg;
    logic        empty;

    logic [SUM_W-1:0]      sum_mag;
    logic [DIV_W-1:0]      pct_dividend;
    logic [DIV_W-1:0]      dividend;
    logic [QUO_W-1:0]      quotient;
    logic [QUO_W-1:0]      mean_mag_reg;
    logic [TEMP_W-1:0]     mean_abs;

    logic                     ok_out_reg;
    logic                     above_out_reg;
    logic [RUN_W-1:0]         run_out_reg;
    logic                     alarm_out_reg;
    logic [COUNT_BITS-1:0]    count_out_reg;
    logic signed [TEMP_W-1:0] max_out_reg;
    logic signed [TEMP_W-1:0] min_out_reg;
    logic [COUNT_BITS-1:0]    acnt_out_reg;
    logic signed [TEMP_W-1:0] mean_out_reg;
    logic [PCT_W-1:0]         pct_out_reg;

    assign cfg_ready = 1'b1;
    assign out_busy  = out_valid_reg && out_stall;

    tras_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .out_busy (out_busy),
        .in_stall (in_stall),
        .ctrl     (ctrl)
    );

    tras_stats u_stats (
        .clk         (clk),
        .rst_n       (rst_n),
        .sample_load (in_valid && !in_stall),
        .temperature (temperature),
        .update      (ctrl.update),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .stats       (stats)
    );

    assign sum_neg      = stats.sum[SUM_W-1];
    assign sum_mag      = sum_neg ? SUM_W'(-stats.sum) : SUM_W'(stats.sum);
    assign pct_dividend = DIV_W'(stats.above_cnt) * DIV_W'(PCT_SCALE);
    assign dividend     = ctrl.div_sel_pct ? pct_dividend : DIV_W'(sum_mag);
    assign empty        = (stats.count == '0);

    tras_div u_div (
        .clk      (clk),
        .load     (ctrl.div_load),
        .step     (ctrl.div_step),
        .dividend (dividend),
        .divisor  (stats.count),
        .quotient (quotient)
    );

    always_ff @(posedge clk)
    begin
        if (ctrl.mean_save)
        begin
            mean_mag_reg <= quotient;
        end
    end

    assign mean_abs = mean_mag_reg[TEMP_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.out_load)
        begin
            ok_out_reg    <= stats.sample_ok;
            above_out_reg <= stats.above;
            run_out_reg   <= stats.run;
            alarm_out_reg <= stats.alarm;
            count_out_reg <= stats.count;
            acnt_out_reg  <= stats.above_cnt;
            max_out_reg   <= empty ? '0 : stats.max_val;
            min_out_reg   <= empty ? '0 : stats.min_val;
            mean_out_reg  <= empty ? '0 : (sum_neg ? -mean_abs : mean_abs);
            pct_out_reg   <= empty ? '0 : quotient[PCT_W-1:0];
        end
    end

    assign out_valid     = out_valid_reg;
    assign sample_valid  = ok_out_reg;
    assign above_limit   = above_out_reg;
    assign run_length    = run_out_reg;
    assign alarm         = alarm_out_reg;
    assign reading_count = count_out_reg;
    assign highest       = max_out_reg;
    assign lowest        = min_out_reg;
    assign above_count   = acnt_out_reg;
    assign mean_temp     = mean_out_reg;
    assign percent_above = pct_out_reg;

endmodule

@@ tb/threshold_run_alarm_stats_unit_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// threshold_run_alarm_stats_unit_tb
// Self-checking bench for the temperature statistics and run alarm unit.
// ----------------------------------------------------------------------------
// A directed table covers the sample range edges, threshold corners and the
// empty-statistics case. Randomized phases then run under several threshold
// and run-length settings, with random input gaps and output stalls. One
// phase includes a long output hold-off. Every result transfer is checked
// field by field against a typed table row or an in-bench statistics model.
// The run ends with a zero run length: the next counted sample latches the alarm.
// ----------------------------------------------------------------------------
module threshold_run_alarm_stats_unit_tb
    import tras_pkg::*;
();

    localparam int N_DIR        = 25;
    localparam int N_PHASES     = 6;
    localparam int PHASE_ITEMS  = 190;
    localparam int FINAL_ITEMS  = 40;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 40;
    localparam int TIMEOUT_NS   = 2000000;
    localparam int COUNT_LIMIT  = (1 << COUNT_BITS) - 1;

    typedef struct packed {
        logic                     sample_ok;
        logic                     above;
        logic [RUN_W-1:0]         run;
        logic                     alarm;
        logic [COUNT_BITS-1:0]    count;
        logic signed [TEMP_W-1:0] hi;
        logic signed [TEMP_W-1:0] lo;
        logic [COUNT_BITS-1:0]    above_cnt;
        logic signed [TEMP_W-1:0] mean;
        logic [PCT_W-1:0]         pct;
    } temp_report_t;

    typedef enum logic {ROW_SAMPLE, ROW_CONFIG} row_kind_t;

    typedef struct packed {
        row_kind_t            kind;
        logic [CFG_IDX_W-1:0] index;
        logic [TEMP_W-1:0]    value;
        logic                 typed;
        temp_report_t         report;
    } dir_row_t;

    localparam temp_report_t EMPTY_REPORT = '0;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    logic signed [TEMP_W-1:0] temperature;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [CFG_DATA_W-1:0]    cfg_data;
    logic                     out_valid;
    logic                     out_stall;
    logic                     sample_valid;
    logic                     above_limit;
    logic [RUN_W-1:0]         run_length;
    logic                     alarm;
    logic [COUNT_BITS-1:0]    reading_count;
    logic signed [TEMP_W-1:0] highest;
    logic signed [TEMP_W-1:0] lowest;
    logic [COUNT_BITS-1:0]    above_count;
    logic signed [TEMP_W-1:0] mean_temp;
    logic [PCT_W-1:0]         percent_above;

    int  cfg_threshold = 0;
    int  cfg_run_len   = 3;
    int  stat_count    = 0;
    int  stat_sum      = 0;
    int  stat_max      = 0;
    int  stat_min      = 0;
    int  stat_above    = 0;
    int  stat_run      = 0;
    bit  stat_alarm    = 1'b0;

    temp_report_t pending_reports [$];
    int           mismatch_count = 0;
    int           gap_rate       = 3;
    int           stall_rate     = 3;
    bit           quiet          = 1'b0;
    bit           hold_req       = 1'b0;
    dir_row_t     dir_rows [N_DIR];

    threshold_run_alarm_stats_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .temperature   (temperature),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .sample_valid  (sample_valid),
        .above_limit   (above_limit),
        .run_length    (run_length),
        .alarm         (alarm),
        .reading_count (reading_count),
        .highest       (highest),
        .lowest        (lowest),
        .above_count   (above_count),
        .mean_temp     (mean_temp),
        .percent_above (percent_above)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic temp_report_t predict_report(input logic [TEMP_W-1:0] raw);
        temp_report_t r;
        int           t;
        bit           ok;
        bit           up;
        t  = $signed(raw);
        ok = !stat_alarm && t >= int'(TEMP_LOW) && t <= int'(TEMP_HIGH);
        up = ok && t > cfg_threshold;
        if (ok)
        begin
            if (stat_count == 0)
            begin
                stat_max = t;
                stat_min = t;
            end
            else
            begin
                if (t > stat_max)
                    stat_max = t;
                if (t < stat_min)
                    stat_min = t;
            end
            if (stat_count < COUNT_LIMIT)
            begin
                stat_count++;
                stat_sum += t;
                if (up)
                    stat_above++;
            end
            if (up)
            begin
                if (stat_run < int'(RUN_MAX))
                    stat_run++;
            end
            else
                stat_run = 0;
            if (stat_run >= cfg_run_len)
                stat_alarm = 1'b1;
        end
        r           = EMPTY_REPORT;
        r.sample_ok = ok;
        r.above     = up;
        r.run       = stat_run[RUN_W-1:0];
        r.alarm     = stat_alarm;
        r.count     = stat_count[COUNT_BITS-1:0];
        r.above_cnt = stat_above[COUNT_BITS-1:0];
        if (stat_count != 0)
        begin
            r.hi   = stat_max[TEMP_W-1:0];
            r.lo   = stat_min[TEMP_W-1:0];
            r.mean = TEMP_W'(stat_sum / stat_count);
            r.pct  = PCT_W'((stat_above * int'(PCT_SCALE)) / stat_count);
        end
        return r;
    endfunction

    // Mixed sample draw; an above sample that would complete the run is swapped
    // for one that is not, so the alarm stays clear until the last phase.
    function automatic logic [TEMP_W-1:0] draw_temperature();
        int pick;
        int t;
        int base;
        int lim;
        pick = $urandom_range(0, 99);
        if (pick < 8)
            t = int'($urandom_range(0, 4095)) - 2048;
        else if (pick < 12)
        begin
            case ($urandom_range(0, 5))
                0:       t = -2048;
                1:       t = 2047;
                2:       t = -800;
                3:       t = 1600;
                4:       t = -801;
                default: t = 1601;
            endcase
        end
        else if (pick < 30)
            t = cfg_threshold + int'($urandom_range(0, 4)) - 2;
        else
        begin
            base = (cfg_threshold + 1 < -800) ? -800 : cfg_threshold + 1;
            if (pick < 65 && base <= 1600)
                t = base + int'($urandom_range(0, 1600 - base));
            else
                t = -800 + int'($urandom_range(0, 2400));
        end
        if (t < -2048)
            t = -2048;
        if (t > 2047)
            t = 2047;
        if (!stat_alarm && t >= -800 && t <= 1600 && t > cfg_threshold
            && stat_run + 1 >= cfg_run_len)
        begin
            if (cfg_threshold >= -800)
            begin
                lim = (cfg_threshold < 1600) ? cfg_threshold : 1600;
                t   = -800 + int'($urandom_range(0, lim + 800));
            end
            else
                t = 1601 + int'($urandom_range(0, 446));
        end
        return t[TEMP_W-1:0];
    endfunction

    task automatic send_sample(input logic [TEMP_W-1:0] t, input bit typed,
                               input temp_report_t want);
        temp_report_t predicted;
        cfg_valid = 1'b0;
        if (!quiet && gap_rate != 0 && $urandom_range(0, 9) < gap_rate)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clk);
        end
        in_valid    = 1'b1;
        temperature = t;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predicted = predict_report(t);
        pending_reports.push_back(typed ? want : predicted);
        @(negedge clk);
    endtask

    task automatic drain_outputs();
        in_valid = 1'b0;
        while (pending_reports.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == REG_THRESHOLD)
            cfg_threshold = $signed(data);
        else
            cfg_run_len = data[RUN_W-1:0];
        @(negedge clk);
    endtask

    task automatic check_field(input string field, input int want, input int got);
        if (want != got)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("%0t: %s expected %0d got %0d", $time, field, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        temp_report_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_reports.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: result transfer with none outstanding", $time);
            end
            else
            begin
                want = pending_reports.pop_front();
                check_field("sample_valid", want.sample_ok, sample_valid);
                check_field("above_limit", want.above, above_limit);
                check_field("run_length", want.run, run_length);
                check_field("alarm", want.alarm, alarm);
                check_field("reading_count", want.count, reading_count);
                check_field("highest", $signed(want.hi), highest);
                check_field("lowest", $signed(want.lo), lowest);
                check_field("above_count", want.above_cnt, above_count);
                check_field("mean_temp", $signed(want.mean), mean_temp);
                check_field("percent_above", want.pct, percent_above);
            end
        end
    end

    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_stall = 1'b1;
                for (int n = 1; n < HOLD_CYCLES; n++)
                    @(negedge clk);
                hold_req = 1'b0;
            end
            else if (!quiet && stall_rate != 0 && $urandom_range(0, 9) < stall_rate)
            begin
                out_stall = 1'b1;
                repeat ($urandom_range(0, 13)) @(negedge clk);
            end
            else
                out_stall = 1'b0;
        end
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("threshold_run_alarm_stats_unit: mismatch");
        $finish;
    end

    initial
    begin
        int         thr;
        int         len;
        logic [3:0] pad;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        temperature = '0;
        cfg_valid   = 1'b0;
        cfg_index   = REG_THRESHOLD;
        cfg_data    = '0;

        dir_rows = '{
            '{ROW_SAMPLE, REG_THRESHOLD, 12'h800,     1'b1, EMPTY_REPORT},
            '{ROW_SAMPLE, REG_THRESHOLD, 12'h7FF,     1'b1, EMPTY_REPORT},
            '{ROW_SAMPLE, REG_THRESHOLD, -12'sd801,   1'b1, EMPTY_REPORT},
            '{ROW_SAMPLE, REG_THRESHOLD, 12'sd1601,   1'b1, EMPTY_REPORT},
            '{ROW_SAMPLE, REG_THRESHOLD, -12'sd800,   1'b1,
              '{1'b1, 1'b0, 8'd0, 1'b0, 16'd1, -12'sd800, -12'sd800, 16'd0,
                -12'sd800, 14'd0}},
            '{ROW_SAMPLE, REG_THRESHOLD, 12'sd1600,   1'b1,
              '{1'b1, 1'b1, 8'd1, 1'b0, 16'd2, 12'sd1600, -12'sd800, 16'd1,
                12'sd400, 14'd5000}},
            '{ROW_SAMPLE, REG_THRESHOLD, 12'sd0,      1'b0, EMPTY_REPORT},
            '{ROW_SAMPLE, REG_THRESHOLD, 12'sd1,      1'b0, EMPTY_REPORT},
            '{ROW_SAMPLE, REG_THRESHOLD, 12'sd2,      1'b0, EMPTY_REPORT},
            '{ROW_SAMPLE, REG_THRESHOLD, -12'sd1,     1'b0, EMPTY_REPORT},
            '{ROW_CONFIG, REG_THRESHOLD, 12'sd1600,   1'b0, EMPTY_REPORT},
            '{ROW_SAMPLE, REG_THRESHOLD, 12'sd1600,   1'b0, EMPTY_REPORT},
            '{ROW_SAMPLE, REG_THRESHOLD, 12'sd1601,   1'b0, EMPTY_REPORT},
            '{ROW_CONFIG, REG_THRESHOLD, -12'sd800,   1'b0, EMPTY_REPORT},
            '{ROW_SAMPLE, REG_THRESHOLD, -12'sd800,   1'b0, EMPTY_REPORT},
            '{ROW_SAMPLE, REG_THRESHOLD, -12'sd799,   1'b0, EMPTY_REPORT},
            '{ROW_CONFIG, REG_RUN_LEN,   12'h0FF,     1'b0, EMPTY_REPORT},
            '{ROW_CONFIG, REG_THRESHOLD, 12'h800,     1'b0, EMPTY_REPORT},
            '{ROW_SAMPLE, REG_THRESHOLD, 12'sd1000,   1'b0, EMPTY_REPORT},
            '{ROW_SAMPLE, REG_THRESHOLD, -12'sd800,   1'b0, EMPTY_REPORT},
            '{ROW_SAMPLE, REG_THRESHOLD, 12'h800,     1'b0, EMPTY_REPORT},
            '{ROW_CONFIG, REG_THRESHOLD, 12'h7FF,     1'b0, EMPTY_REPORT},
            '{ROW_SAMPLE, REG_THRESHOLD, 12'sd1600,   1'b0, EMPTY_REPORT},
            '{ROW_CONFIG, REG_RUN_LEN,   12'h001,     1'b0, EMPTY_REPORT},
            '{ROW_SAMPLE, REG_THRESHOLD, 12'sd1234,   1'b0, EMPTY_REPORT}
        };

        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int i = 0; i < N_DIR; i++)
        begin
            if (dir_rows[i].kind == ROW_CONFIG)
            begin
                drain_outputs();
                write_register(dir_rows[i].index, dir_rows[i].value);
            end
            else
                send_sample(dir_rows[i].value, dir_rows[i].typed, dir_rows[i].report);
        end

        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    thr = -800 + int'($urandom_range(0, 2400));
                    len = $urandom_range(2, 10);
                end
                1:
                begin
                    thr = 1600;
                    len = 1;
                end
                2:
                begin
                    thr = -800;
                    len = 255;
                end
                3:
                begin
                    thr = int'($urandom_range(0, 4095)) - 2048;
                    len = $urandom_range(1, 255);
                end
                4:
                begin
                    thr = -800 + int'($urandom_range(0, 2400));
                    len = $urandom_range(4, 8);
                end
                default:
                begin
                    thr = int'($urandom_range(0, 200)) - 100;
                    len = 2;
                end
            endcase
            gap_rate   = (ph == 1) ? 0 : $urandom_range(1, 5);
            stall_rate = (ph == 1) ? 0 : $urandom_range(1, 5);
            pad        = 4'($urandom_range(0, 15));
            drain_outputs();
            write_register(REG_THRESHOLD, thr[TEMP_W-1:0]);
            write_register(REG_RUN_LEN, {pad, len[RUN_W-1:0]});
            if (ph == 3)
                hold_req = 1'b1;
            repeat (PHASE_ITEMS)
                send_sample(draw_temperature(), 1'b0, EMPTY_REPORT);
        end

        // zero run length: the next counted sample latches the alarm
        drain_outputs();
        quiet = 1'b1;
        pad   = 4'($urandom_range(0, 15));
        write_register(REG_RUN_LEN, {pad, 8'd0});
        write_register(REG_THRESHOLD, '0);
        repeat (FINAL_ITEMS)
            send_sample(draw_temperature(), 1'b0, EMPTY_REPORT);
        drain_outputs();
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatch_count == 0 && pending_reports.size() == 0)
            $display("threshold_run_alarm_stats_unit: match");
        else
            $display("threshold_run_alarm_stats_unit: mismatch");
        $finish;
    end

endmodule
